@@ sv/sobel_pkg.sv @@
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; sobel_edge_magnitude, sobel_lines and sobel_kernel import this package, sobel_ram does not.
`default_nettype none
package sobel_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int CoordW   = 11;
  localparam int SizeW    = 12;
  localparam int LineAddrW = $clog2(MaxWidth);
  localparam int CfgIdxW  = 1;
  localparam int OutDataW = 48;

  localparam logic [SizeW-1:0] MinSize     = SizeW'(3);
  localparam logic [SizeW-1:0] WidthReset  = SizeW'(640);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(480);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // Position and border information that travels with each pixel.
  typedef struct packed {
    logic              interior;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } meta_t;

endpackage
`default_nettype wire

@@ sv/sobel_edge_magnitude.sv @@
// Streaming 3x3 Sobel edge magnitude over blue, green and red pixels.
// Pipeline: each pixel passes the line read, window and output registers; its result is
// then offered on m_axis_tdata and held there while m_axis_tready is low.
// Throughput: one pixel per cycle unless output stalls; one RAM reads and writes back.
// Reset: asynchronous, active low. A clearing pass over all 2048 line-store entries follows,
// with s_axis_tready low; configuration writes are taken throughout.
// Depends on sobel_pkg, sobel_lines, sobel_kernel and sobel_ram.
`default_nettype none
module sobel_edge_magnitude (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // Fields from bit 0: blue_in, green_in, red_in.
  input  wire logic [sobel_pkg::PixW-1:0]      s_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: blue_edge, green_edge, red_edge, centre_row, centre_col, zero pad.
  output      logic [sobel_pkg::OutDataW-1:0]  m_axis_tdata,
  // Field: interior.
  output      logic [0:0]                      m_axis_tuser,
  input  wire logic                            cfg_we_i,
  input  wire logic [sobel_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sobel_pkg::SizeW-1:0]     cfg_data_i
);
  import sobel_pkg::*;

  logic [SizeW-1:0]  width_q, height_q, w_eff, h_eff;
  logic [CoordW-1:0] col_q, row_q;
  logic [SizeW-1:0]  col_inc, row_inc;
  logic              accept;
  logic              interior_c;
  meta_t             meta_c;

  logic              v1_q;
  pix_t              px1_q;
  logic [CoordW-1:0] col1_q;
  meta_t             meta1_q;
  logic              rdy1, rdy2, fire1;
  logic              lines_ready;
  pix_t              top_rd, mid_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameWidth:  width_q  <= cfg_data_i;
        RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < MinSize) begin
      w_eff = MinSize;
    end else if (width_q > SizeW'(MaxWidth)) begin
      w_eff = SizeW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q < MinSize) begin
      h_eff = MinSize;
    end else if (height_q > SizeW'(MaxHeight)) begin
      h_eff = SizeW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1 && lines_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire1         = v1_q && rdy2;

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  // A position left beyond the frame by a size change counts as border.
  assign interior_c = (row_q >= CoordW'(2)) && (col_q >= CoordW'(2)) &&
                      ({1'b0, row_q} < h_eff) && ({1'b0, col_q} < w_eff);

  always_comb begin
    meta_c.interior = interior_c;
    meta_c.row      = interior_c ? (row_q - 1'b1) : '0;
    meta_c.col      = interior_c ? (col_q - 1'b1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= accept;
      end
      if (accept) begin
        if (col_inc >= w_eff) begin
          col_q <= '0;
          row_q <= (row_inc >= h_eff) ? '0 : row_inc[CoordW-1:0];
        end else begin
          col_q <= col_inc[CoordW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q   <= s_axis_tdata;
      col1_q  <= col_q;
      meta1_q <= meta_c;
    end
  end

  sobel_lines u_lines (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(col_q[LineAddrW-1:0]),
    .wr_en_i  (fire1),
    .wr_addr_i(col1_q[LineAddrW-1:0]),
    .wr_pix_i (px1_q),
    .top_o    (top_rd),
    .mid_o    (mid_rd),
    .ready_o  (lines_ready)
  );

  sobel_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (v1_q),
    .in_ready_o   (rdy2),
    .top_i        (top_rd),
    .mid_i        (mid_rd),
    .bot_i        (px1_q),
    .meta_i       (meta1_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  a_accept_reaches_read_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted pixel missing from the read stage");

  a_no_pixel_before_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lines_ready |-> !v1_q)
    else $error("pixel in flight during line store clearing");

endmodule
`default_nettype wire

@@ sv/sobel_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
`default_nettype none
module sobel_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/sobel_lines.sv @@
// Two line stores held side by side in one RAM, with the clearing pass after reset.
// Depends on sobel_pkg and sobel_ram.
`default_nettype none
module sobel_lines (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             rd_en_i,
  input  wire logic [sobel_pkg::LineAddrW-1:0]  rd_addr_i,
  input  wire logic                             wr_en_i,
  input  wire logic [sobel_pkg::LineAddrW-1:0]  wr_addr_i,
  input  wire sobel_pkg::pix_t                  wr_pix_i,
  output      sobel_pkg::pix_t                  top_o,
  output      sobel_pkg::pix_t                  mid_o,
  output      logic                             ready_o
);
  import sobel_pkg::*;

  logic [LineAddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic                 clr_done_q, clr_done_d;

  logic                 ram_we;
  logic [LineAddrW-1:0] ram_waddr;
  logic [2*PixW-1:0]    ram_wdata;
  logic [2*PixW-1:0]    ram_rdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_done_q <= clr_done_d;
    end
  end

  // Entry layout is {upper row, middle row}. The write shifts the middle row
  // up and stores the incoming pixel as the new middle row.
  always_comb begin
    if (!clr_done_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_en_i;
      ram_waddr = wr_addr_i;
      ram_wdata = {ram_rdata[PixW-1:0], wr_pix_i};
    end
  end

  sobel_ram #(
    .Width(2 * PixW),
    .Depth(MaxWidth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  assign top_o   = ram_rdata[2*PixW-1:PixW];
  assign mid_o   = ram_rdata[PixW-1:0];
  assign ready_o = clr_done_q;

  a_no_read_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> clr_done_q)
    else $error("line store read during clearing pass");

  a_no_same_entry_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en_i) |-> (rd_addr_i != wr_addr_i))
    else $error("read and write-back hit the same line store entry");

endmodule
`default_nettype wire

@@ sv/sobel_kernel.sv @@
// 3x3 window, per-channel Sobel magnitude and the output register.
// Depends on sobel_pkg.
`default_nettype none
module sobel_kernel (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire sobel_pkg::pix_t                 top_i,
  input  wire sobel_pkg::pix_t                 mid_i,
  input  wire sobel_pkg::pix_t                 bot_i,
  input  wire sobel_pkg::meta_t                meta_i,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: blue_edge, green_edge, red_edge, centre_row, centre_col, zero pad.
  output      logic [sobel_pkg::OutDataW-1:0]  m_axis_tdata,
  // Field: interior.
  output      logic [0:0]                      m_axis_tuser
);
  import sobel_pkg::*;

  function automatic logic [ChanW-1:0] chan_edge(
    input logic [ChanW-1:0] t0, input logic [ChanW-1:0] t1, input logic [ChanW-1:0] t2,
    input logic [ChanW-1:0] m0, input logic [ChanW-1:0] m2,
    input logic [ChanW-1:0] b0, input logic [ChanW-1:0] b1, input logic [ChanW-1:0] b2
  );
    logic [ChanW+1:0] gy_p, gy_n, gx_p, gx_n, ay, ax;
    logic [ChanW+2:0] sum;
    logic [ChanW:0]   quot;
    gy_p = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, b2};
    gy_n = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
    gx_p = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, b2};
    gx_n = {2'b00, t0} + {1'b0, m0, 1'b0} + {2'b00, b0};
    ay   = (gy_p >= gy_n) ? (gy_p - gy_n) : (gy_n - gy_p);
    ax   = (gx_p >= gx_n) ? (gx_p - gx_n) : (gx_n - gx_p);
    sum  = {1'b0, ay} + {1'b0, ax};
    quot = sum[ChanW+2:2];
    return quot[ChanW] ? {ChanW{1'b1}} : quot[ChanW-1:0];
  endfunction

  // Window indexed [channel][row top..bottom][column left..right].
  logic [ChanW-1:0] win_q [3][3][3];
  meta_t            meta2_q;
  logic             v2_q;
  logic             v3_q;
  meta_t            meta3_q;
  logic [ChanW-1:0] edge_q [3];
  logic [ChanW-1:0] edge_d [3];
  logic             rdy2, rdy3, load;

  assign rdy3       = !v3_q || m_axis_tready;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;
  assign load       = in_valid_i && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      win_q <= '{default: '0};
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (load) begin
        for (int ch = 0; ch < 3; ch++) begin
          for (int r = 0; r < 3; r++) begin
            win_q[ch][r][0] <= win_q[ch][r][1];
            win_q[ch][r][1] <= win_q[ch][r][2];
          end
          win_q[ch][0][2] <= top_i[ch*ChanW +: ChanW];
          win_q[ch][1][2] <= mid_i[ch*ChanW +: ChanW];
          win_q[ch][2][2] <= bot_i[ch*ChanW +: ChanW];
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      edge_d[ch] = meta2_q.interior
                 ? chan_edge(win_q[ch][0][0], win_q[ch][0][1], win_q[ch][0][2],
                             win_q[ch][1][0], win_q[ch][1][2],
                             win_q[ch][2][0], win_q[ch][2][1], win_q[ch][2][2])
                 : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      meta2_q <= meta_i;
    end
    if (rdy3 && v2_q) begin
      meta3_q <= meta2_q;
      edge_q  <= edge_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = meta3_q.interior;
  assign m_axis_tdata  = {2'b00, meta3_q.col, meta3_q.row, edge_q[2], edge_q[1], edge_q[0]};

  a_border_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !meta3_q.interior) |-> (m_axis_tdata == '0))
    else $error("border result carries nonzero fields");

  a_out_from_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("output became valid without a window item");

  a_load_fills_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> v2_q)
    else $error("window stage lost a loaded item");

endmodule
`default_nettype wire
